// File: hw/rtl/srgo_pkg.sv
// Shared types, constants and the sine table of the Shepard-Risset oscillator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package srgo_pkg;

    localparam int TABLE_SIZE = 2048;
    localparam int PARTIALS   = 7;
    localparam int ROM_BITS   = $clog2(TABLE_SIZE);
    localparam int FRAC_SHIFT = 32 - ROM_BITS - 12;
    localparam int K_W        = $clog2(PARTIALS);

    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [31:0] LOG2E_Q30   = 32'd1549082005;
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] INV_SQRT2PI = 32'd428361012;
    localparam logic [35:0] CENTER_Q30  = 36'd4831838208;
    localparam logic [35:0] Y_LIMIT     = 36'd23622320128;

    typedef logic signed [24:0] rom_word_t;
    typedef rom_word_t rom_array_t [0:TABLE_SIZE];

    // floor((2^32-1)/i) for the division steps of the exponential series.
    localparam logic [31:0] RECIP [1:12] = '{
        32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
        32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
        32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
    };

    typedef enum logic [1:0] {
        CFG_GAIN = 2'd0,
        CFG_BASE = 2'd1,
        CFG_RATE = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_START, OP_ROM, OP_SQ, OP_LOG, OP_FRAC, OP_EXPI, OP_EMUL,
        OP_ERCP, OP_EDIV, OP_WMUL, OP_WSH, OP_VW, OP_ACC, OP_GAIN, OP_OUT, OP_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic k_last;
        logic i_last;
    } dp_status_t;

    // Sine of a Q30 angle in [0, pi/2] as Q1.23, by a ten-term series.
    function automatic rom_word_t sin_q23(logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 272; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 342; sum = sum - signed'(term);
        if (sum < 0) sum = 0;
        sum = (sum + 64) >>> 7;
        if (sum > 64'sd8388608) sum = 64'sd8388608;
        return rom_word_t'(sum);
    endfunction

    function automatic rom_array_t build_rom();
        rom_array_t  r;
        int unsigned j;
        logic        neg;
        rom_word_t   s;
        for (int i = 0; i <= TABLE_SIZE; i++) begin
            j   = i % TABLE_SIZE;
            neg = 1'b0;
            if (j >= TABLE_SIZE / 2) begin
                neg = 1'b1;
                j   = j - TABLE_SIZE / 2;
            end
            if (2 * j > TABLE_SIZE / 2) j = TABLE_SIZE / 2 - j;
            s    = sin_q23((TWO_PI_Q30 * 64'(j)) / TABLE_SIZE);
            r[i] = neg ? -s : s;
        end
        return r;
    endfunction

    localparam rom_array_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

// File: hw/rtl/shepard_risset_glissando_osc.sv
// Shepard-Risset endless-glissando oscillator, top level.
// An accepted item runs its 7 partials in turn, each with the exponential series
// taken to the 12th power on the shared multiplier, then gain, output and update.
// Flow: an item is taken only once the last is done, also while its sample waits.
// Reset: synchronous active-low aresetn clears config and phase, sweep position to 1.0.
`default_nettype none

module shepard_risset_glissando_osc (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [23:0] sample
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import srgo_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    srgo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srgo_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (s_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .sample    (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while an item is in work");

    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("sample appeared without an item in work");

    a_start_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (cmd.op == OP_START))
        else $error("accepted item did not start the sequence");

endmodule

`default_nettype wire

// File: hw/rtl/srgo_datapath.sv
// Datapath of the oscillator: configuration, phase and sweep state, sine ROM,
// shared 32x32 multiplier, Gaussian weight and accumulator. Uses srgo_pkg.
`default_nettype none

module srgo_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   restart,
    input  srgo_pkg::dp_cmd_t           cmd,
    output srgo_pkg::dp_status_t        status,
    output logic [23:0]                 sample
);
    import srgo_pkg::*;

    logic [15:0]        gain_reg;
    logic [31:0]        base_reg;
    logic signed [31:0] rate_reg;
    logic [31:0]        phase_reg;
    logic [30:0]        pos_reg;
    logic [K_W-1:0]     k_reg;
    rom_word_t          s0_reg, s1_reg;
    logic [11:0]        fr_reg;
    logic [24:0]        a22_reg;
    logic [63:0]        prod_reg;
    logic signed [37:0] ip_reg;
    logic signed [25:0] v_reg;
    logic               zero_reg;
    logic [4:0]         n_reg;
    logic [29:0]        u_reg;
    logic [30:0]        term_reg;
    logic [30:0]        x_reg;
    logic signed [32:0] esum_reg;
    logic [3:0]         i_reg;
    logic [29:0]        w_reg;
    logic signed [56:0] vw_reg;
    logic signed [59:0] acc_reg;
    logic signed [46:0] gprod_reg;
    logic [23:0]        out_reg;

    logic [31:0]        mul_a, mul_b;
    logic [31:0]        ph;
    logic [ROM_BITS-1:0] idx;
    logic [ROM_BITS:0]  idx1;
    logic signed [35:0] d;
    logic [35:0]        ad;
    logic [35:0]        y;
    logic [36:0]        t;
    logic [30:0]        q0, q;
    logic [34:0]        r;
    logic signed [29:0] sum;
    logic signed [30:0] smp;
    logic [34:0]        s;
    logic signed [33:0] np;
    logic [31:0]        phase_next;
    logic signed [33:0] pos_next;

    always_comb begin
        ph   = phase_reg << k_reg;
        idx  = ph[31 -: ROM_BITS];
        idx1 = {1'b0, idx} + 1'b1;
        d    = signed'(36'({k_reg, 30'd0})) - signed'(CENTER_Q30) + signed'(36'(pos_reg));
        ad   = (d < 0) ? 36'(-d) : 36'(d);
        y    = prod_reg[49:14];
        t    = prod_reg[61:25];
        q0   = prod_reg[62:32];
        r    = 35'(x_reg) - 35'(q0) * 35'(i_reg);
        q    = (r >= 35'(i_reg)) ? q0 + 31'd1 : q0;
        sum  = 30'(acc_reg >>> 30);
        smp  = 31'(gprod_reg >>> 16);
        s    = 35'(phase_reg) + 35'(prod_reg[63:30]);
        np   = signed'(34'(pos_reg)) + 34'(rate_reg);
        phase_next = s[31:0];
        pos_next   = np;
        if (np < 34'sd1073741824) begin
            pos_next   = np + 34'sd1073741824;
            phase_next = {s[30:0], 1'b0};
            if (pos_next < 34'sd1073741824) pos_next = 34'sd1073741824;
        end else if (np >= 34'sd2147483648) begin
            pos_next   = np - 34'sd1073741824;
            phase_next = s[32:1];
            if (pos_next >= 34'sd2147483648) pos_next = 34'sd2147483647;
        end
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ:   begin mul_a = 32'(a22_reg);     mul_b = 32'(a22_reg);   end
            OP_LOG:  begin mul_a = 32'(y[35:5]);     mul_b = LOG2E_Q30;      end
            OP_FRAC: begin mul_a = 32'(t[29:0]);     mul_b = LN2_Q30;        end
            OP_EMUL: begin mul_a = 32'(term_reg);    mul_b = 32'(u_reg);     end
            OP_ERCP: begin mul_a = 32'(prod_reg[60:30]); mul_b = RECIP[i_reg]; end
            OP_WMUL: begin mul_a = 32'(esum_reg[30:0]); mul_b = INV_SQRT2PI; end
            OP_GAIN: begin mul_a = base_reg;         mul_b = 32'(pos_reg);   end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= '0;
            base_reg  <= '0;
            rate_reg  <= '0;
            phase_reg <= '0;
            pos_reg   <= 31'h4000_0000;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_GAIN: gain_reg <= cfg_data[15:0];
                    CFG_BASE: base_reg <= cfg_data;
                    CFG_RATE: rate_reg <= signed'(cfg_data);
                    default:  ;
                endcase
            end
            if (cmd.op == OP_START && restart) begin
                phase_reg <= '0;
                pos_reg   <= 31'h4000_0000;
            end
            if (cmd.op == OP_UPD) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next[30:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_START: begin
                k_reg   <= '0;
                acc_reg <= '0;
            end
            OP_ROM: begin
                s0_reg  <= SINE_ROM[idx];
                s1_reg  <= SINE_ROM[idx1];
                fr_reg  <= ph[FRAC_SHIFT +: 12];
                a22_reg <= ad[32:8];
            end
            OP_SQ: begin
                prod_reg <= mul_a * mul_b;
                ip_reg   <= (26'(s1_reg) - 26'(s0_reg)) * signed'({1'b0, fr_reg});
            end
            OP_LOG: begin
                prod_reg <= mul_a * mul_b;
                zero_reg <= (y >= Y_LIMIT);
                v_reg    <= 26'(s0_reg) + 26'(ip_reg >>> 12);
            end
            OP_FRAC: begin
                prod_reg <= mul_a * mul_b;
                n_reg    <= t[34:30];
                if (t[36:30] >= 7'd31) zero_reg <= 1'b1;
            end
            OP_EXPI: begin
                u_reg    <= prod_reg[59:30];
                term_reg <= 31'h4000_0000;
                esum_reg <= 33'sh0_4000_0000;
                i_reg    <= 4'd1;
            end
            OP_EMUL: prod_reg <= mul_a * mul_b;
            OP_ERCP: begin
                x_reg    <= prod_reg[60:30];
                prod_reg <= mul_a * mul_b;
            end
            OP_EDIV: begin
                term_reg <= q;
                esum_reg <= i_reg[0] ? esum_reg - signed'(33'(q)) : esum_reg + signed'(33'(q));
                i_reg    <= i_reg + 4'd1;
            end
            OP_WMUL: prod_reg <= mul_a * mul_b;
            OP_WSH:  w_reg <= zero_reg ? '0 : 30'(prod_reg[60:30] >> n_reg);
            OP_VW:   vw_reg <= v_reg * signed'({1'b0, w_reg});
            OP_ACC: begin
                acc_reg <= acc_reg + 60'(vw_reg);
                k_reg   <= k_reg + 1'b1;
            end
            OP_GAIN: begin
                prod_reg  <= mul_a * mul_b;
                gprod_reg <= sum * signed'({1'b0, gain_reg});
            end
            OP_OUT: begin
                if (smp > 31'sd8388607)       out_reg <= 24'h7F_FFFF;
                else if (smp < -31'sd8388608) out_reg <= 24'h80_0000;
                else                          out_reg <= smp[23:0];
            end
            default: ;
        endcase
    end

    assign status.k_last = (k_reg == K_W'(PARTIALS - 1));
    assign status.i_last = (i_reg == 4'd12);
    assign sample        = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/srgo_ctrl.sv
// Sequencer of the oscillator: one-hot state machine that steps the datapath
// through the partials and the series loop, and owns both handshakes. Uses srgo_pkg.
`default_nettype none

module srgo_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  srgo_pkg::dp_status_t status,
    output srgo_pkg::dp_cmd_t    cmd
);
    import srgo_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001, ST_ROM  = 16'h0002, ST_SQ   = 16'h0004, ST_LOG  = 16'h0008,
        ST_FRAC = 16'h0010, ST_EXPI = 16'h0020, ST_EMUL = 16'h0040, ST_ERCP = 16'h0080,
        ST_EDIV = 16'h0100, ST_WMUL = 16'h0200, ST_WSH  = 16'h0400, ST_VW   = 16'h0800,
        ST_ACC  = 16'h1000, ST_GAIN = 16'h2000, ST_OUT  = 16'h4000, ST_UPD  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        cmd.op     = OP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_START;
                    state_next = ST_ROM;
                end
            end
            ST_ROM:  begin cmd.op = OP_ROM;  state_next = ST_SQ;   end
            ST_SQ:   begin cmd.op = OP_SQ;   state_next = ST_LOG;  end
            ST_LOG:  begin cmd.op = OP_LOG;  state_next = ST_FRAC; end
            ST_FRAC: begin cmd.op = OP_FRAC; state_next = ST_EXPI; end
            ST_EXPI: begin cmd.op = OP_EXPI; state_next = ST_EMUL; end
            ST_EMUL: begin cmd.op = OP_EMUL; state_next = ST_ERCP; end
            ST_ERCP: begin cmd.op = OP_ERCP; state_next = ST_EDIV; end
            ST_EDIV: begin
                cmd.op     = OP_EDIV;
                state_next = status.i_last ? ST_WMUL : ST_EMUL;
            end
            ST_WMUL: begin cmd.op = OP_WMUL; state_next = ST_WSH;  end
            ST_WSH:  begin cmd.op = OP_WSH;  state_next = ST_VW;   end
            ST_VW:   begin cmd.op = OP_VW;   state_next = ST_ACC;  end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = status.k_last ? ST_GAIN : ST_ROM;
            end
            ST_GAIN: begin cmd.op = OP_GAIN; state_next = ST_OUT;  end
            ST_OUT: begin
                // The finished sample waits here until the output register is free.
                if (out_free) begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:  begin cmd.op = OP_UPD;  state_next = ST_IDLE; end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire
